>>> design/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the fixed-point square matrix multiplier:
// channel payloads, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mm4_pkg;

	// Element width of A and B (signed Q8.8); a result is SUM_W bits (signed Q19.16).
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = 35;

	// Largest supported matrix size and the address width it needs.
	localparam int MAX_DIM = 8;
	localparam int MAX_AW  = $clog2(MAX_DIM * MAX_DIM);

	// One input transaction: same-position elements of A and B.
	typedef struct packed {
		logic signed [ELEM_W-1:0] a_value;
		logic signed [ELEM_W-1:0] b_value;
	} in_t;

	// One output transaction: one element of C.
	typedef struct packed {
		logic signed [SUM_W-1:0] product_value;
		logic                    is_last;
	} out_t;

	// Controller states.
	typedef enum logic {
		ST_LOAD,
		ST_CALC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              wr_en;
		logic [MAX_AW-1:0] wr_addr;
		logic              rd_en;
		logic [MAX_AW-1:0] a_addr;
		logic [MAX_AW-1:0] b_addr;
		logic              first;
		logic              last_k;
		logic              last_elem;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv;
	} stat_t;

endpackage

>>> design/matrix_multiply_4x4_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_top
// Square matrix product C = A x B in signed fixed point, DIM x DIM elements.
// ----------------------------------------------------------------------------
// Each input transaction carries one Q8.8 element of A and the element of B
// at the same position, in row-major order. The input takes one transaction
// per cycle while loading; after the DIM*DIM-th one it stalls while the
// product is formed. One multiply-accumulate unit reading one element of
// each store per cycle, unless a full output register is stalled, computes
// C. Products pass the store read registers and the multiplier register,
// and each finished sum goes to the output register; the elements of C
// appear in row-major order as exact Q19.16 sums, and is_last marks the
// final one. The input is accepted again as soon as the last
// multiply-accumulate is issued.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_top #(
	parameter int DIM = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  mm4_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output mm4_pkg::out_t result
);
	import mm4_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencing of loads and multiply-accumulates.
	mm4_ctrl #(.DIM(DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Stores, multiplier, accumulator and output register.
	mm4_dp #(.DIM(DIM)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

>>> design/mm4_ram.sv
// ----------------------------------------------------------------------------
// mm4_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mm4_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/mm4_ctrl.sv
// ----------------------------------------------------------------------------
// mm4_ctrl
// Controller: counts loaded elements, then walks row, column and inner index
// to issue one multiply-accumulate per cycle to the datapath while it advances.
// ----------------------------------------------------------------------------
module mm4_ctrl #(
	parameter int DIM = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  mm4_pkg::stat_t stat,
	output mm4_pkg::cmd_t  cmd
);
	import mm4_pkg::*;

	localparam int NELEM = DIM * DIM;
	localparam int AW    = $clog2(NELEM);
	localparam int IW    = $clog2(DIM);

	localparam logic [AW-1:0] LAST_LOAD = AW'(NELEM - 1);
	localparam logic [AW-1:0] DIM_A     = AW'(DIM);
	localparam logic [IW-1:0] LAST_IDX  = IW'(DIM - 1);

	state_t        state_q, state_nxt;
	logic [AW-1:0] load_cnt_q;
	logic [IW-1:0] row_q, col_q, k_q;
	logic [AW-1:0] row_a, col_a, k_a;
	logic [AW-1:0] a_idx, b_idx;
	logic          load_acc, last_k, last_elem;

	assign load_acc  = (state_q == ST_LOAD) && item_valid;
	assign last_k    = (k_q == LAST_IDX);
	assign last_elem = (row_q == LAST_IDX) && (col_q == LAST_IDX) && last_k;

	// Row-major addresses of A[row][k] and B[k][col].
	assign row_a = AW'(row_q);
	assign col_a = AW'(col_q);
	assign k_a   = AW'(k_q);
	assign a_idx = row_a * DIM_A + k_a;
	assign b_idx = k_a * DIM_A + col_a;

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_acc && (load_cnt_q == LAST_LOAD)) begin
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				if (stat.adv && last_elem) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// Output logic.
	always_comb begin
		item_stall    = 1'b1;
		cmd           = '0;
		cmd.wr_addr   = MAX_AW'(load_cnt_q);
		cmd.a_addr    = MAX_AW'(a_idx);
		cmd.b_addr    = MAX_AW'(b_idx);
		cmd.first     = (k_q == '0);
		cmd.last_k    = last_k;
		cmd.last_elem = last_elem;
		case (state_q)
			ST_LOAD: begin
				item_stall = 1'b0;
				cmd.wr_en  = item_valid;
			end
			ST_CALC: begin
				cmd.rd_en = stat.adv;
			end
			default: item_stall = 1'b1;
		endcase
	end

	// State, load counter and index counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			k_q        <= '0;
		end else begin
			state_q <= state_nxt;
			if (load_acc) begin
				load_cnt_q <= (load_cnt_q == LAST_LOAD) ? '0 : load_cnt_q + 1'b1;
			end
			if ((state_q == ST_CALC) && stat.adv) begin
				if (last_k) begin
					k_q <= '0;
					if (col_q == LAST_IDX) begin
						col_q <= '0;
						row_q <= (row_q == LAST_IDX) ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> design/mm4_dp.sv
// ----------------------------------------------------------------------------
// mm4_dp
// Datapath: element stores for A and B, one multiplier, the accumulator and
// the output register. The whole compute pipeline halts only while the
// output register is full and stalled.
// ----------------------------------------------------------------------------
module mm4_dp #(
	parameter int DIM = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mm4_pkg::cmd_t  cmd,
	output mm4_pkg::stat_t stat,
	input  mm4_pkg::in_t   item,
	output logic           result_valid,
	input  logic           result_stall,
	output mm4_pkg::out_t  result
);
	import mm4_pkg::*;

	localparam int NELEM = DIM * DIM;
	localparam int AW    = $clog2(NELEM);

	logic                     adv;
	logic [ELEM_W-1:0]        a_rd, b_rd;
	logic                     v_s1, first_s1, lastk_s1, lastel_s1;
	logic                     v_s2, first_s2, lastk_s2, lastel_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q, sum_nxt;
	logic                     out_valid_q;
	out_t                     out_q;

	// The pipeline moves unless a finished result is waiting and stalled.
	assign adv      = !out_valid_q || !result_stall;
	assign stat.adv = adv;

	// Element stores.
	mm4_ram #(.WIDTH(ELEM_W), .DEPTH(NELEM)) u_left_store (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(cmd.wr_addr[AW-1:0]),
		.wr_data(item.a_value),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.a_addr[AW-1:0]),
		.rd_data(a_rd)
	);

	mm4_ram #(.WIDTH(ELEM_W), .DEPTH(NELEM)) u_right_store (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(cmd.wr_addr[AW-1:0]),
		.wr_data(item.b_value),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.b_addr[AW-1:0]),
		.rd_data(b_rd)
	);

	// Control tags that follow the read data down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			first_s1  <= 1'b0;
			lastk_s1  <= 1'b0;
			lastel_s1 <= 1'b0;
			v_s2      <= 1'b0;
			first_s2  <= 1'b0;
			lastk_s2  <= 1'b0;
			lastel_s2 <= 1'b0;
		end else if (adv) begin
			v_s1      <= cmd.rd_en;
			first_s1  <= cmd.first;
			lastk_s1  <= cmd.last_k;
			lastel_s1 <= cmd.last_elem;
			v_s2      <= v_s1;
			first_s2  <= first_s1;
			lastk_s2  <= lastk_s1;
			lastel_s2 <= lastel_s1;
		end
	end

	// Multiplier stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(a_rd) * $signed(b_rd);
		end
	end

	// The first product of an element starts a new sum.
	assign sum_nxt = first_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);

	// Accumulator and output payload.
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= sum_nxt;
			if (lastk_s2) begin
				out_q.product_value <= sum_nxt;
				out_q.is_last       <= lastel_s2;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s2 && lastk_s2) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> design/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker #(
	parameter int DIM = 4
) (
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_stall,
	input logic          result_valid,
	input logic          result_stall,
	input mm4_pkg::out_t result
);
	import mm4_pkg::*;

	localparam int NELEM = DIM * DIM;
	localparam int AW    = $clog2(NELEM);
	localparam int PW    = $clog2(4 * NELEM);

	localparam logic [AW-1:0] LAST = AW'(NELEM - 1);

	logic          in_acc, out_acc, done;
	logic [AW-1:0] in_cnt_q, out_cnt_q;
	logic [PW-1:0] pend_q;

	assign in_acc  = item_valid && !item_stall;
	assign out_acc = result_valid && !result_stall;
	assign done    = in_acc && (in_cnt_q == LAST);

	// Positions within the input and output matrices, and results still owed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			pend_q    <= '0;
		end else begin
			if (in_acc) begin
				in_cnt_q <= (in_cnt_q == LAST) ? '0 : in_cnt_q + 1'b1;
			end
			if (out_acc) begin
				out_cnt_q <= (out_cnt_q == LAST) ? '0 : out_cnt_q + 1'b1;
			end
			pend_q <= pend_q + (done ? PW'(NELEM) : '0) - (out_acc ? PW'(1) : '0);
		end
	end

	// A stalled result transaction holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The last flag marks exactly the final element of each product matrix.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (result.is_last == (out_cnt_q == LAST)))
		else $error("is_last out of place");

	// Completing a matrix pair is followed by a stall on the input.
	a_stall_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> item_stall)
		else $error("input not stalled after a complete matrix pair");

	// No result appears unless a completed matrix pair still owes one.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pend_q != '0))
		else $error("result without a completed matrix pair");

endmodule

bind matrix_multiply_4x4_top mm4_checker #(.DIM(DIM)) u_mm4_checker (.*);
